FILE: rtl/core/refcount_block_table_defines.svh
// assertion macros used by the checker of the block table
`ifndef REFCOUNT_BLOCK_TABLE_DEFINES_SVH
`define REFCOUNT_BLOCK_TABLE_DEFINES_SVH

// same-cycle implication, masked during reset
`define RBT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbt check failed");

// next-cycle implication, masked during reset
`define RBT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbt check failed");

// next-cycle implication that also holds across reset
`define RBT_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("rbt check failed");

`endif

FILE: rtl/core/rbt_pkg.sv
package rbt_pkg;

   localparam int CMD_W       = 3;
   localparam int ID_W        = 7;
   localparam int IN_SIZE_W   = 20;
   localparam int STATUS_W    = 3;
   localparam int VALUE_W     = 20;
   localparam int USED_W      = 27;
   localparam int LIMIT_W     = 26;
   localparam int AVAIL_W     = 27;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 80;

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE  = 3'd0,
      CMD_RESIZE  = 3'd1,
      CMD_ADD_REF = 3'd2,
      CMD_DEL_REF = 3'd3,
      CMD_CLEAR   = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_BAD_ID  = 3'd1,
      ST_OVER    = 3'd2,
      ST_NO_REFS = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

endpackage

FILE: rtl/core/refcount_block_table.sv
// path: a request is read from the memories into the read stage at accept, then its
// response goes to the output register; it is held longer only while rsp_tready is low
// throughput: one request per cycle while the response side does not stall, the memory read of a
// request overlapping the read-modify-write of the one before it, with write data forwarded on an address match
// reset: synchronous, clears block count, used total, memory limit and the valids;
// the size and reference memories are not cleared and hold no data until written
module refcount_block_table
   import rbt_pkg::*;
#(
   parameter int MAX_BLOCKS = 64,
   parameter int SIZE_BITS  = 20,
   parameter int REF_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // cmd[2:0], block_id[9:3], block_size[29:10], zero[31:30]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status[2:0], value[22:3], used_total[48:23], available[75:49], zero[79:76]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [LIMIT_W-1:0]     csr_data
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int EXT_W = (IDX_W > ID_W) ? IDX_W : ID_W;
   localparam int IDC_W = (CNT_W > ID_W) ? CNT_W : ID_W;
   localparam int CMP_W = ((USED_W > SIZE_BITS) ? USED_W : SIZE_BITS) + 1;
   localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

   logic [SIZE_BITS-1:0] size_mem [MAX_BLOCKS];
   logic [REF_BITS-1:0]  ref_mem  [MAX_BLOCKS];

   logic                 req_accept;
   logic [IDX_W-1:0]     rd_addr;

   logic                 s1_valid_ff, s1_valid_in;
   cmd_type              s1_cmd_ff;
   logic [ID_W-1:0]      s1_id_ff;
   logic [IN_SIZE_W-1:0] s1_size_ff;
   logic [IDX_W-1:0]     s1_idx_ff;
   logic [SIZE_BITS-1:0] size_rd_ff, size_fwd_data_ff;
   logic [REF_BITS-1:0]  ref_rd_ff, ref_fwd_data_ff;
   logic                 size_fwd_ff, ref_fwd_ff;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [USED_W-1:0]    used_ff, used_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic                 out_free;
   logic                 s1_fire;
   logic                 size_we, ref_we;
   logic [IDX_W-1:0]     wr_addr;
   logic [SIZE_BITS-1:0] size_wdata;
   logic [REF_BITS-1:0]  ref_wdata;
   logic [SIZE_BITS-1:0] size_old, size_new;
   logic [REF_BITS-1:0]  ref_old;
   logic                 id_ok;
   status_type           status;
   logic [VALUE_W-1:0]   value;
   logic [AVAIL_W-1:0]   avail;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_accept = req_tvalid && req_tready;
   assign rd_addr    = IDX_W'(EXT_W'(req_tdata[9:3]) - EXT_W'(1));

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // table memories: one read port at accept, one write port from the modify stage
   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem[wr_addr] <= size_wdata;
      end
      if (ref_we) begin
         ref_mem[wr_addr] <= ref_wdata;
      end
      if (req_accept) begin
         size_rd_ff <= size_mem[rd_addr];
         ref_rd_ff  <= ref_mem[rd_addr];
      end
   end

   // a write at the same edge as the read is not seen by the read, so keep it aside
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff        <= cmd_type'(req_tdata[2:0]);
         s1_id_ff         <= req_tdata[9:3];
         s1_size_ff       <= req_tdata[29:10];
         s1_idx_ff        <= rd_addr;
         size_fwd_ff      <= size_we && (wr_addr == rd_addr);
         ref_fwd_ff       <= ref_we && (wr_addr == rd_addr);
         size_fwd_data_ff <= size_wdata;
         ref_fwd_data_ff  <= ref_wdata;
      end
      if (s1_fire) begin
         rsp_data_ff <= {(RSP_TDATA_W - AVAIL_W - LIMIT_W - VALUE_W - STATUS_W)'(0),
                         avail, used_in[LIMIT_W-1:0], value, status};
      end
   end

   always_comb begin
      size_old = size_fwd_ff ? size_fwd_data_ff : size_rd_ff;
      ref_old  = ref_fwd_ff ? ref_fwd_data_ff : ref_rd_ff;
      size_new = SIZE_BITS'(s1_size_ff);
      id_ok    = (IDC_W'(s1_id_ff) != IDC_W'(0)) && (IDC_W'(s1_id_ff) <= IDC_W'(count_ff));

      count_in   = count_ff;
      used_in    = used_ff;
      status     = ST_OK;
      value      = '0;
      size_we    = 1'b0;
      ref_we     = 1'b0;
      wr_addr    = s1_idx_ff;
      size_wdata = size_new;
      ref_wdata  = ref_old;

      unique case (s1_cmd_ff)
         CMD_CREATE: begin
            if (count_ff >= CNT_W'(MAX_BLOCKS)) begin
               status = ST_FULL;
            end else begin
               wr_addr   = count_ff[IDX_W-1:0];
               size_we   = 1'b1;
               ref_we    = 1'b1;
               ref_wdata = '0;
               count_in  = count_ff + 1'b1;
               used_in   = USED_W'(CMP_W'(used_ff) + CMP_W'(size_new));
               value     = VALUE_W'(count_in);
            end
         end
         CMD_RESIZE: begin
            if (!id_ok) begin
               status = ST_BAD_ID;
            end else if ((CMP_W'(used_ff) + CMP_W'(size_new)) >
                         (CMP_W'(limit_ff) + CMP_W'(size_old))) begin
               status = ST_OVER;
            end else begin
               size_we = 1'b1;
               used_in = USED_W'(CMP_W'(used_ff) + CMP_W'(size_new) - CMP_W'(size_old));
               value   = VALUE_W'(size_new);
            end
         end
         CMD_ADD_REF: begin
            if (!id_ok) begin
               status = ST_BAD_ID;
            end else begin
               ref_we    = 1'b1;
               ref_wdata = (ref_old == REF_MAX) ? ref_old : ref_old + 1'b1;
               value     = VALUE_W'(ref_wdata);
            end
         end
         CMD_DEL_REF: begin
            if (!id_ok) begin
               status = ST_BAD_ID;
            end else if (ref_old == '0) begin
               status = ST_NO_REFS;
            end else begin
               ref_we    = 1'b1;
               ref_wdata = ref_old - 1'b1;
               value     = VALUE_W'(ref_wdata);
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
            used_in  = '0;
         end
         default: begin
         end
      endcase

      if (!s1_fire) begin
         size_we  = 1'b0;
         ref_we   = 1'b0;
         count_in = count_ff;
         used_in  = used_ff;
      end

      avail = AVAIL_W'(USED_W'(limit_ff) - used_in);
   end

   always_comb begin
      s1_valid_in = req_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      limit_in = csr_valid ? csr_data : limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         used_ff      <= '0;
         limit_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         limit_ff     <= limit_in;
      end
   end

endmodule

FILE: rtl/core/rbt_checker.sv
`include "refcount_block_table_defines.svh"

module rbt_checker
   import rbt_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0]  rsp_value;
   logic                rsp_stall;

   assign rsp_status = rsp_tdata[STATUS_W-1:0];
   assign rsp_value  = rsp_tdata[STATUS_W+VALUE_W-1:STATUS_W];
   assign rsp_stall  = rsp_tvalid && !rsp_tready;

   // no response is pending right after reset
   `RBT_ASSERT_NXT_ALL(a_reset_empty, clock, reset, !rsp_tvalid)
   // a stalled response holds
   `RBT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   // errors carry a zero value
   `RBT_ASSERT_IMP(a_err_value, clock, reset, rsp_tvalid && (rsp_status != ST_OK), rsp_value == '0)
   // status stays within the defined codes
   `RBT_ASSERT_IMP(a_status_code, clock, reset, rsp_tvalid, rsp_status <= ST_FULL)

endmodule

bind refcount_block_table rbt_checker u_rbt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/sv/refcount_block_table_checker.sv
module refcount_block_table_checker
   import rbt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [LIMIT_W-1:0]     csr_data,
   output int                     fail_count,
   output int                     pending_count
);

   localparam int TABLE_DEPTH = 64;
   localparam logic [15:0] REF_CEILING = 16'hFFFF;

   typedef struct {
      status_type                  status;
      logic [VALUE_W-1:0]          value;
      logic [LIMIT_W-1:0]          used_total;
      logic signed [AVAIL_W-1:0]   available;
   } table_result_type;

   logic [IN_SIZE_W-1:0] block_size_mem [TABLE_DEPTH];
   logic [15:0]          ref_count_mem  [TABLE_DEPTH];
   logic [ID_W-1:0]      blocks_in_use;
   logic [USED_W-1:0]    used_sum;
   logic [LIMIT_W-1:0]   limit_reg;
   table_result_type     expected_results [$];
   int                   fail_total = 0;

   assign fail_count = fail_total;

   task automatic report_mismatch(input string field_name, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("mismatch on %s: expected 0x%0h, got 0x%0h", field_name, want, got);
      fail_total++;
   endtask

   function automatic table_result_type apply_command(input logic [CMD_W-1:0] cmd,
                                                      input logic [ID_W-1:0] id,
                                                      input logic [IN_SIZE_W-1:0] sz);
      table_result_type r;
      logic          id_ok;
      logic [5:0]    slot;
      logic [USED_W:0] grown;
      logic [USED_W:0] budget;
      r.status = ST_OK;
      r.value  = '0;
      id_ok    = (id != '0) && (id <= blocks_in_use);
      slot     = 6'(id - 7'd1);
      case (cmd)
         CMD_CREATE: begin
            if (blocks_in_use >= TABLE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               block_size_mem[blocks_in_use[5:0]] = sz;
               ref_count_mem[blocks_in_use[5:0]]  = '0;
               blocks_in_use = blocks_in_use + 7'd1;
               used_sum      = used_sum + sz;
               r.value       = VALUE_W'(blocks_in_use);
            end
         end
         CMD_RESIZE: begin
            if (!id_ok) begin
               r.status = ST_BAD_ID;
            end else begin
               // compare without wrap: used - old + new against the limit
               grown  = {1'b0, used_sum} + sz;
               budget = (USED_W+1)'(limit_reg) + block_size_mem[slot];
               if (grown > budget) begin
                  r.status = ST_OVER;
               end else begin
                  used_sum             = used_sum + sz - block_size_mem[slot];
                  block_size_mem[slot] = sz;
                  r.value              = sz;
               end
            end
         end
         CMD_ADD_REF: begin
            if (!id_ok) begin
               r.status = ST_BAD_ID;
            end else begin
               if (ref_count_mem[slot] != REF_CEILING)
                  ref_count_mem[slot] = ref_count_mem[slot] + 16'd1;
               r.value = VALUE_W'(ref_count_mem[slot]);
            end
         end
         CMD_DEL_REF: begin
            if (!id_ok) begin
               r.status = ST_BAD_ID;
            end else if (ref_count_mem[slot] == '0) begin
               r.status = ST_NO_REFS;
            end else begin
               ref_count_mem[slot] = ref_count_mem[slot] - 16'd1;
               r.value = VALUE_W'(ref_count_mem[slot]);
            end
         end
         CMD_CLEAR: begin
            blocks_in_use = '0;
            used_sum      = '0;
         end
         default: ;
      endcase
      r.used_total = used_sum[LIMIT_W-1:0];
      r.available  = {1'b0, limit_reg} - used_sum;
      return r;
   endfunction

   always @(posedge clock) begin
      table_result_type want;
      table_result_type got;
      if (reset) begin
         blocks_in_use = '0;
         used_sum      = '0;
         limit_reg     = '0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            block_size_mem[i] = '0;
            ref_count_mem[i]  = '0;
         end
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready)
            limit_reg = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            got.status     = status_type'(rsp_tdata[2:0]);
            got.value      = rsp_tdata[22:3];
            got.used_total = rsp_tdata[48:23];
            got.available  = rsp_tdata[75:49];
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response", '0, rsp_tdata[31:0]);
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", want.status, got.status);
               if (got.value !== want.value)
                  report_mismatch("value", want.value, got.value);
               if (got.used_total !== want.used_total)
                  report_mismatch("used_total", want.used_total, got.used_total);
               if (got.available !== want.available)
                  report_mismatch("available", want.available, got.available);
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_command(req_tdata[2:0], req_tdata[9:3],
                                                     req_tdata[29:10]));
      end
      pending_count <= expected_results.size();
   end

endmodule

FILE: tb/sv/refcount_block_table_tb.sv
module refcount_block_table_tb
   import rbt_pkg::*;
();

   localparam int TABLE_DEPTH     = 64;
   localparam int ITEMS_PER_PHASE = 175;
   localparam int LONG_HOLD       = 300;
   localparam int STALL_LIMIT     = 2000;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [LIMIT_W-1:0]     csr_data;

   int fail_count;
   int pending_count;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_trigger  = 0;
   int table_fill    = 0;
   int quiet_cycles  = 0;

   refcount_block_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   refcount_block_table_checker table_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // response side: random backpressure, plus a long hold-off on request
   initial begin
      int hold_left;
      int hold_seen;
      hold_left  = 0;
      hold_seen  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && hold_seen != hold_trigger) begin
            hold_seen = hold_trigger;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                               input logic [IN_SIZE_W-1:0] sz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, sz, id, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // track the table size only to steer the random ids
      if (cmd == CMD_CREATE && table_fill < TABLE_DEPTH)
         table_fill++;
      else if (cmd == CMD_CLEAR)
         table_fill = 0;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] limit);
      csr_valid <= 1'b1;
      csr_data  <= limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_command();
      logic [CMD_W-1:0]     cmd;
      logic [ID_W-1:0]      id;
      logic [IN_SIZE_W-1:0] sz;
      int                   pick;
      pick = $urandom_range(99);
      case ($urandom_range(9))
         0:          sz = '0;
         1:          sz = '1;
         2, 3, 4, 5: sz = IN_SIZE_W'($urandom_range(4095));
         default:    sz = IN_SIZE_W'($urandom);
      endcase
      if ($urandom_range(99) < 15) begin
         // noise: any command code, any id
         cmd = CMD_W'($urandom);
         id  = ID_W'($urandom);
      end else begin
         case ($urandom_range(2))
            0:       cmd = CMD_RESIZE;
            1:       cmd = CMD_ADD_REF;
            default: cmd = CMD_DEL_REF;
         endcase
         if (table_fill == 0)
            cmd = CMD_CREATE;
         else if (table_fill == TABLE_DEPTH && pick < 15)
            cmd = CMD_CREATE;
         else if (table_fill == TABLE_DEPTH && pick < 25)
            cmd = CMD_CLEAR;
         else if (table_fill < TABLE_DEPTH && pick < 30)
            cmd = CMD_CREATE;
         else if (table_fill < TABLE_DEPTH && pick < 31)
            cmd = CMD_CLEAR;
         if (table_fill == 0)
            id = '0;
         else if ($urandom_range(99) < 5)
            id = ID_W'(table_fill + 1);
         else
            id = ID_W'($urandom_range(table_fill, 1));
      end
      send_request(cmd, id, sz);
   endtask

   initial begin
      logic [LIMIT_W-1:0] phase_limit;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct <= 28;
      recv_idle_pct <= 66;
      write_limit(26'd1000);

      send_request(CMD_CREATE, '0, '0);
      send_request(CMD_CREATE, '0, '1);              // create past the limit
      send_request(CMD_RESIZE, 7'd2, '1);            // still over the limit
      send_request(CMD_RESIZE, 7'd2, '0);
      send_request(CMD_RESIZE, 7'd1, 20'd1000);      // exactly at the limit
      send_request(CMD_RESIZE, 7'd1, 20'd1001);
      send_request(CMD_ADD_REF, 7'd1, '0);
      send_request(CMD_DEL_REF, 7'd1, '0);
      send_request(CMD_DEL_REF, 7'd1, '0);           // count already zero
      send_request(CMD_ADD_REF, '0, '0);
      send_request(CMD_RESIZE, 7'd3, 20'd5);         // one past the last block
      send_request(CMD_DEL_REF, '1, '1);
      send_request(3'd5, '1, '1);
      send_request(3'd6, '0, '0);
      send_request(3'd7, 7'h55, 20'hAAAAA);
      send_request(CMD_CLEAR, '1, '1);
      send_request(CMD_ADD_REF, 7'd1, '0);
      send_request(CMD_CREATE, 7'h2A, 20'h5A5A5);

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         case (phase)
            0:       phase_limit = '1;
            1:       phase_limit = '0;
            2:       phase_limit = LIMIT_W'($urandom_range(40000000, 20000000));
            3:       phase_limit = LIMIT_W'($urandom_range(8000000, 1000000));
            4:       phase_limit = LIMIT_W'($urandom);
            default: phase_limit = LIMIT_W'($urandom_range(60000000, 30000000));
         endcase
         write_limit(phase_limit);
         case (phase / 2)
            0: begin
               send_idle_pct <= 28;
               recv_idle_pct <= 66;
            end
            1: begin
               send_idle_pct <= 66;
               recv_idle_pct <= 28;
            end
            default: begin
               send_idle_pct <= 0;
               recv_idle_pct <= 0;
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 0 && n == 60)
               hold_trigger <= hold_trigger + 1;
            if (n == 120)
               drain();
            send_random_command();
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
